/* rtl/v4alu_pkg.sv */
// ----------------------------------------------------------------------------
// v4alu_pkg
// Types and constants for the four-component Q8.8 vector unit pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package v4alu_pkg;

	localparam int unsigned COMP_W   = 16;
	localparam int unsigned SCALAR_W = 34;
	localparam int unsigned ROOT_W   = 17;
	localparam int unsigned QUO_W    = 9;
	localparam int unsigned REM_W    = 25;
	localparam int unsigned SQ_STEPS = ROOT_W;
	localparam int unsigned DV_STEPS = QUO_W;
	localparam int unsigned NUM_STG  = SQ_STEPS + DV_STEPS;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_SCALE = 3'd2,
		OP_DOT   = 3'd3,
		OP_LEN   = 3'd4,
		OP_NORM  = 3'd5
	} opcode_t;

	typedef struct packed {
		opcode_t                      op;
		logic [3:0][COMP_W-1:0]       vec;
		logic                         ovf;
		logic [SCALAR_W-1:0]          dot;
		logic [SCALAR_W-1:0]          rad;
		logic [SCALAR_W-1:0]          root;
		logic [3:0][REM_W-1:0]        rem;
		logic [3:0][QUO_W-1:0]        quo;
		logic [3:0]                   neg;
	} pipe_t;

endpackage

`default_nettype wire

/* rtl/vec4_alu.sv */
// ----------------------------------------------------------------------------
// vec4_alu
// Pipelined four-component Q8.8 vector unit: add, sub, scale, dot, length
// and normalize, one request per cycle while the output is not held.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+----
//  input   | in_valid, in_ready, opcode, a_*, b_*,    | in
//          | scale_factor                             |
//  output  | out_valid, out_ready, out_x..out_w,      | out
//          | scalar_out, overflow                     |
//
// Stages from input to output handshake: multiply, sum/saturate,
// 17 square-root steps, 8 division steps, output register that also takes
// the ninth division step. One request enters per cycle unless held.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vec4_alu (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [2:0]            opcode,
	input  wire logic signed [15:0]    a_x,
	input  wire logic signed [15:0]    a_y,
	input  wire logic signed [15:0]    a_z,
	input  wire logic signed [15:0]    a_w,
	input  wire logic signed [15:0]    b_x,
	input  wire logic signed [15:0]    b_y,
	input  wire logic signed [15:0]    b_z,
	input  wire logic signed [15:0]    b_w,
	input  wire logic signed [15:0]    scale_factor,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [15:0]         out_x,
	output logic signed [15:0]         out_y,
	output logic signed [15:0]         out_z,
	output logic signed [15:0]         out_w,
	output logic signed [33:0]         scalar_out,
	output logic                       overflow
);

	import v4alu_pkg::*;

	function automatic logic [COMP_W:0] sat16(input logic signed [31:0] v);
		logic [COMP_W:0] res;
		if (v > 32'sd32767) begin
			res = {1'b1, 16'h7fff};
		end else if (v < -32'sd32768) begin
			res = {1'b1, 16'h8000};
		end else begin
			res = {1'b0, v[15:0]};
		end
		return res;
	endfunction

	logic en;
	logic signed [15:0] ain [4];
	logic signed [15:0] bin [4];

	opcode_t                    op_s1;
	logic                       vld_s1;
	logic signed [15:0]         a_s1   [4];
	logic signed [15:0]         b_s1   [4];
	logic signed [31:0]         pab_s1 [4];
	logic signed [31:0]         paf_s1 [4];
	logic signed [31:0]         paa_s1 [4];

	pipe_t                      pipe_s2 [NUM_STG];
	logic [NUM_STG-1:0]         vld_s2;
	pipe_t                      head;

	logic                       vld_q;
	logic [3:0][COMP_W-1:0]     vec_q;
	logic [SCALAR_W-1:0]        scl_q;
	logic                       ovf_q;

	assign en       = !vld_q || out_ready;
	assign in_ready = en;

	assign ain[0] = a_x;
	assign ain[1] = a_y;
	assign ain[2] = a_z;
	assign ain[3] = a_w;
	assign bin[0] = b_x;
	assign bin[1] = b_y;
	assign bin[2] = b_z;
	assign bin[3] = b_w;

	// stage 1: multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= opcode_t'(opcode);
			for (int i = 0; i < 4; i++) begin
				a_s1[i]   <= ain[i];
				b_s1[i]   <= bin[i];
				pab_s1[i] <= ain[i] * bin[i];
				paf_s1[i] <= ain[i] * scale_factor;
				paa_s1[i] <= ain[i] * ain[i];
			end
		end
	end

	// stage 2: sums, saturation, setup of root and divide
	always_comb begin
		logic signed [16:0]       sum;
		logic signed [31:0]       sc;
		logic [COMP_W:0]          st;
		logic signed [SCALAR_W-1:0] dacc;
		logic [SCALAR_W-1:0]      sacc;
		logic [15:0]              mag;
		head      = '0;
		head.op   = op_s1;
		dacc      = '0;
		sacc      = '0;
		for (int i = 0; i < 4; i++) begin
			dacc = dacc + SCALAR_W'(pab_s1[i]);
			sacc = sacc + SCALAR_W'(paa_s1[i]);
			if (op_s1 == OP_SUB) begin
				sum = 17'(a_s1[i]) - 17'(b_s1[i]);
			end else begin
				sum = 17'(a_s1[i]) + 17'(b_s1[i]);
			end
			sc = paf_s1[i] >>> 8;
			if (op_s1 == OP_SCALE) begin
				st = sat16(sc);
			end else begin
				st = sat16(32'(sum));
			end
			head.vec[i] = st[15:0];
			if (op_s1 == OP_ADD || op_s1 == OP_SUB || op_s1 == OP_SCALE) begin
				head.ovf = head.ovf | st[16];
			end
			head.neg[i] = a_s1[i][15];
			mag         = a_s1[i][15] ? 16'(-a_s1[i]) : a_s1[i];
			head.rem[i] = {1'b0, mag, 8'h00};
		end
		head.dot  = dacc;
		head.rad  = sacc;
		head.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= '0;
		end else if (en) begin
			vld_s2 <= {vld_s2[NUM_STG-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s2[0] <= head;
		end
	end

	// square root: one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SCALAR_W-1:0] BIT = SCALAR_W'(1) << (2 * (SQ_STEPS - 1 - k));
		pipe_t nxt;
		always_comb begin
			logic [SCALAR_W-1:0] trial;
			nxt   = pipe_s2[k];
			trial = pipe_s2[k].root + BIT;
			if (pipe_s2[k].rad >= trial) begin
				nxt.rad  = pipe_s2[k].rad - trial;
				nxt.root = (pipe_s2[k].root >> 1) + BIT;
			end else begin
				nxt.root = pipe_s2[k].root >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s2[k+1] <= nxt;
			end
		end
	end

	// normalize: one quotient bit per stage, four lanes
	for (genvar j = 0; j < DV_STEPS - 1 + 1; j++) begin : g_div
		localparam int unsigned T   = DV_STEPS - 1 - j;
		localparam int unsigned SRC = 1 + SQ_STEPS + j - 1;
		if (SRC + 1 < NUM_STG) begin : g_stg
			pipe_t nxt;
			always_comb begin
				logic [REM_W:0] d;
				nxt = pipe_s2[SRC];
				d   = (REM_W+1)'(pipe_s2[SRC].root[ROOT_W-1:0]) << T;
				for (int i = 0; i < 4; i++) begin
					if ({1'b0, pipe_s2[SRC].rem[i]} >= d) begin
						nxt.rem[i]    = pipe_s2[SRC].rem[i] - d[REM_W-1:0];
						nxt.quo[i][T] = 1'b1;
					end
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s2[SRC+1] <= nxt;
				end
			end
		end else begin : g_last
			pipe_t                  fin;
			logic [3:0][COMP_W-1:0] nrm;
			always_comb begin
				logic [REM_W:0] d;
				fin = pipe_s2[SRC];
				d   = (REM_W+1)'(pipe_s2[SRC].root[ROOT_W-1:0]) << T;
				for (int i = 0; i < 4; i++) begin
					if ({1'b0, pipe_s2[SRC].rem[i]} >= d) begin
						fin.rem[i]    = pipe_s2[SRC].rem[i] - d[REM_W-1:0];
						fin.quo[i][T] = 1'b1;
					end
				end
				for (int i = 0; i < 4; i++) begin
					if (fin.root == '0) begin
						nrm[i] = '0;
					end else if (fin.neg[i]) begin
						nrm[i] = -COMP_W'(fin.quo[i]);
					end else begin
						nrm[i] = COMP_W'(fin.quo[i]);
					end
				end
			end
			// output register
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q <= 1'b0;
				end else if (en) begin
					vld_q <= vld_s2[NUM_STG-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					unique case (fin.op)
						OP_ADD, OP_SUB, OP_SCALE: begin
							vec_q <= fin.vec;
							scl_q <= '0;
							ovf_q <= fin.ovf;
						end
						OP_DOT: begin
							vec_q <= '0;
							scl_q <= fin.dot;
							ovf_q <= 1'b0;
						end
						OP_LEN: begin
							vec_q <= '0;
							scl_q <= fin.root;
							ovf_q <= 1'b0;
						end
						OP_NORM: begin
							vec_q <= nrm;
							scl_q <= '0;
							ovf_q <= 1'b0;
						end
						default: begin
							vec_q <= '0;
							scl_q <= '0;
							ovf_q <= 1'b0;
						end
					endcase
				end
			end
		end
	end

	assign out_valid  = vld_q;
	assign out_x      = vec_q[0];
	assign out_y      = vec_q[1];
	assign out_z      = vec_q[2];
	assign out_w      = vec_q[3];
	assign scalar_out = scl_q;
	assign overflow   = ovf_q;

endmodule

`default_nettype wire

/* test/vec4_alu_tb.sv */
// ----------------------------------------------------------------------------
// vec4_alu_tb
// Drives add, sub, scale, dot, length, normalize and unused-opcode requests through the
// vector unit with random idling on both channels, predicts each result
// in fixed point and compares every output field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module vec4_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import v4alu_pkg::*;

	typedef struct {
		logic [2:0]         op;
		logic signed [15:0] a [4];
		logic signed [15:0] b [4];
		logic signed [15:0] f;
	} vreq_t;

	typedef struct {
		logic signed [15:0] v [4];
		logic signed [33:0] s;
		logic               ovf;
	} vres_t;

	typedef struct {
		vreq_t req;
		bit    fixed;
		vres_t res;
	} row_t;

	localparam int N_RAND = 1300;
	localparam int LIMIT  = 400000;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] opcode;
	logic signed [15:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor;
	logic signed [15:0] out_x, out_y, out_z, out_w;
	logic signed [33:0] scalar_out;
	logic overflow;

	vres_t result_q [$];
	row_t  rows [$];
	int    errors;
	int    cycles;
	bit    quiet_out;

	vec4_alu dut (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic signed [15:0] clamp16(longint v, ref logic ovf);
		if (v > 32767) begin
			ovf = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			ovf = 1'b1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic longint isqrt(longint n);
		longint r;
		r = 0;
		for (int k = 20; k >= 0; k--) begin
			if ((r + (64'sd1 << k)) * (r + (64'sd1 << k)) <= n)
				r = r + (64'sd1 << k);
		end
		return r;
	endfunction

	function automatic vres_t vec_compute(vreq_t q);
		vres_t  r;
		longint a, b, f, acc, len, p;
		r.ovf = 1'b0;
		r.s = '0;
		acc = 0;
		f = q.f;
		for (int i = 0; i < 4; i++) begin
			r.v[i] = '0;
			acc += longint'(q.a[i]) * longint'(q.a[i]);
		end
		len = isqrt(acc);
		for (int i = 0; i < 4; i++) begin
			a = q.a[i];
			b = q.b[i];
			case (q.op)
				OP_ADD: r.v[i] = clamp16(a + b, r.ovf);
				OP_SUB: r.v[i] = clamp16(a - b, r.ovf);
				OP_SCALE: begin
					p = a * f;
					r.v[i] = clamp16(p >>> 8, r.ovf);
				end
				OP_DOT: r.s = r.s + 34'(a * b);
				OP_NORM: if (len != 0) r.v[i] = 16'((a * 256) / len);
				default: ;
			endcase
		end
		if (q.op == OP_LEN)
			r.s = 34'(len);
		return r;
	endfunction

	function automatic vreq_t rand_req();
		vreq_t q;
		int    m;
		q.op = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		m = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			case (m)
				0: q.a[i] = 16'($urandom_range(0, 1) ? 16'sh7fff - $urandom_range(0, 3)
						: 16'sh8000 + $urandom_range(0, 3));
				1: q.a[i] = 16'($signed($urandom_range(0, 1023)) - 512);
				default: q.a[i] = 16'($urandom);
			endcase
			q.b[i] = $urandom_range(0, 3) == 0 ? 16'($signed($urandom_range(0, 511)) - 256)
				: 16'($urandom);
		end
		if ($urandom_range(0, 9) == 0)
			foreach (q.a[i]) q.a[i] = '0;
		q.f = $urandom_range(0, 1) ? 16'($urandom) : 16'($signed($urandom_range(0, 1023)) - 512);
		return q;
	endfunction

	function automatic row_t mk(logic [2:0] op, logic signed [15:0] av,
			logic signed [15:0] bv, logic signed [15:0] f);
		row_t w;
		w.req.op = op;
		foreach (w.req.a[i]) begin
			w.req.a[i] = av;
			w.req.b[i] = bv;
		end
		w.req.f = f;
		w.fixed = 1'b0;
		return w;
	endfunction

	function automatic row_t mkx(row_t w, logic signed [15:0] v, logic signed [33:0] s,
			logic o);
		w.fixed = 1'b1;
		foreach (w.res.v[i]) w.res.v[i] = v;
		w.res.s = s;
		w.res.ovf = o;
		return w;
	endfunction

	task automatic send(vreq_t q, bit fixed, vres_t r);
		while (!quiet_out && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= q.op;
		{a_x, a_y, a_z, a_w} <= {q.a[0], q.a[1], q.a[2], q.a[3]};
		{b_x, b_y, b_z, b_w} <= {q.b[0], q.b[1], q.b[2], q.b[3]};
		scale_factor <= q.f;
		result_q.push_back(fixed ? r : vec_compute(q));
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		row_t w;
		vres_t nil;
		in_valid = 1'b0;
		opcode = '0;
		{a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor} = '0;
		errors = 0;
		quiet_out = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(mkx(mk(OP_ADD, 0, 0, 0), 0, 0, 0));
		rows.push_back(mkx(mk(OP_ADD, 16'sh7fff, 16'sh7fff, 0), 16'sh7fff, 0, 1));
		rows.push_back(mkx(mk(OP_ADD, 16'sh8000, 16'sh8000, 0), 16'sh8000, 0, 1));
		rows.push_back(mkx(mk(OP_SUB, 16'sh8000, 16'sh7fff, 0), 16'sh8000, 0, 1));
		rows.push_back(mkx(mk(OP_SUB, 16'sh7fff, 16'sh8000, 0), 16'sh7fff, 0, 1));
		rows.push_back(mkx(mk(OP_SCALE, 16'sh0100, 0, 16'sh0100), 16'sh0100, 0, 0));
		rows.push_back(mkx(mk(OP_SCALE, 16'sh8000, 0, 16'sh8000), 16'sh7fff, 0, 1));
		rows.push_back(mkx(mk(OP_SCALE, -1, 0, 1), -1, 0, 0));
		rows.push_back(mkx(mk(OP_DOT, 16'sh8000, 16'sh8000, 0), 0, 34'sh100000000, 0));
		rows.push_back(mkx(mk(OP_DOT, 16'sh8000, 16'sh7fff, 0), 0, -34'sh0fffe0000, 0));
		rows.push_back(mkx(mk(OP_LEN, 16'sh8000, 0, 0), 0, 34'sd65536, 0));
		rows.push_back(mkx(mk(OP_LEN, 0, 0, 0), 0, 0, 0));
		rows.push_back(mkx(mk(OP_NORM, 0, 0, 0), 0, 0, 0));
		rows.push_back(mkx(mk(OP_NORM, 16'sh8000, 0, 0), -16'sd128, 0, 0));
		rows.push_back(mk(OP_NORM, 16'sh7fff, 0, 0));
		rows.push_back(mk(OP_SCALE, 16'sh7fff, 0, 16'sh7fff));
		rows.push_back(mkx(mk(3'd6, 16'sh7fff, 16'sh7fff, 16'sh7fff), 0, 0, 0));
		rows.push_back(mkx(mk(3'd7, -1, -1, -1), 0, 0, 0));
		w = mk(OP_NORM, 0, 0, 0);
		w.req.a = '{16'sd3, 16'sd4, 16'sd0, 16'sd0};
		rows.push_back(w);
		w = mk(OP_DOT, 0, 0, 0);
		w.req.a = '{16'sh1234, -16'sd7, 16'sh7fff, 16'sh8000};
		w.req.b = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sh5555};
		rows.push_back(w);
		foreach (rows[i])
			send(rows[i].req, rows[i].fixed, rows[i].res);

		for (int n = 0; n < N_RAND; n++) begin
			quiet_out = (n >= 400 && n < 600);
			send(rand_req(), 1'b0, nil);
		end
		in_valid <= 1'b0;
		quiet_out = 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet_out || $urandom_range(0, 99) >= 22;
		end
	end

	always @(posedge clk) begin
		vres_t e;
		logic signed [15:0] got [4];
		if (arst_n && out_valid && out_ready) begin
			got = '{out_x, out_y, out_z, out_w};
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result", $realtime);
				errors++;
			end else begin
				e = result_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== e.v[i]) begin
						$display("%0t: comp %0d expected %0d actual %0d", $realtime, i,
							e.v[i], got[i]);
						errors++;
					end
				if (scalar_out !== e.s) begin
					$display("%0t: scalar expected %0d actual %0d", $realtime, e.s,
						scalar_out);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$display("%0t: overflow expected %0b actual %0b", $realtime, e.ovf,
						overflow);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial cycles = 0;

endmodule

`default_nettype wire
